/* rtl/core/fws_pkg.sv */
// Package for the force to wheel speed block: widths, codes, state encoding
// and small saturation helpers. No dependencies.
package fws_pkg;

   localparam int FIELD_W    = 24;
   localparam int MODE_W     = 2;
   localparam int REQ_DATA_W = 6 * FIELD_W;
   localparam int RSP_DATA_W = 2 * FIELD_W;
   localparam int RSP_USER_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int DS_NUM_W   = 64;
   localparam int DS_DEN_W   = 25;
   localparam int DS_Q_W     = 56;
   localparam int IM_FRAC    = 16;

   localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_MASS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_GAIN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED    = 2'd2;

   localparam logic signed [PROD_W-1:0] SAT_POS = 66'sd2147483647;
   localparam logic signed [PROD_W-1:0] SAT_NEG = -66'sd2147483647;
   localparam logic [DS_Q_W-1:0] TERM_LIMIT = 56'd1099511627776;

   typedef struct packed {
      logic start;
      logic op_sqrt;
   } ds_req_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_AX, ST_AY, ST_HX2, ST_HY2, ST_H2, ST_SQH,
      ST_D1, ST_D2, ST_D3, ST_D4, ST_D5, ST_DVA,
      ST_PX, ST_PXD, ST_DVX, ST_PY, ST_PYD, ST_DVY,
      ST_V2X, ST_V2Y, ST_V2S, ST_SQS, ST_AN, ST_DVN,
      ST_PT, ST_PTD, ST_DVT, ST_FIN
   } state_type;

   // Returns the saturation flag above the clipped 32-bit value.
   function automatic logic [32:0] sat32(input logic signed [PROD_W-1:0] v);
      logic [32:0] r;
      if (v > SAT_POS) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < SAT_NEG) begin
         r = {1'b1, 32'h8000_0001};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   // Drops the 16 fraction bits of a product with the Q8.16 inverse mass, truncating toward zero.
   function automatic logic signed [PROD_W-1:0] scale_im(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] mag;
      mag = p[PROD_W-1] ? -p : p;
      mag = mag >> IM_FRAC;
      return p[PROD_W-1] ? -mag : mag;
   endfunction

endpackage

/* rtl/core/fws_mul.sv */
// Registered signed multiplier shared by every product of the block.
// Depends on fws_pkg.
module fws_mul (
   input  logic                                clock,
   input  logic signed [fws_pkg::MUL_W-1:0]    mul_a,
   input  logic signed [fws_pkg::MUL_W-1:0]    mul_b,
   output logic signed [fws_pkg::PROD_W-1:0]   prod_ff
);
   import fws_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* rtl/core/fws_divsqrt.sv */
// Bit-serial unsigned divider and floor square root on one compare-subtract.
// Depends on fws_pkg. Division takes 56 steps, square root 32 steps.
module fws_divsqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  fws_pkg::ds_req_type             ds_req,
   input  logic [fws_pkg::DS_NUM_W-1:0]    ds_num,
   input  logic [fws_pkg::DS_DEN_W-1:0]    ds_den,
   output logic                            ds_done,
   output logic [fws_pkg::DS_Q_W-1:0]      ds_q
);
   import fws_pkg::*;

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic                  op_ff, op_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [DS_NUM_W-1:0]   rad_ff, rad_in;
   logic [33:0]           rem_ff, rem_in;
   logic [DS_Q_W-1:0]     q_ff, q_in;
   logic [DS_DEN_W-1:0]   den_ff, den_in;
   logic [33:0]           cmp_a, cmp_b;
   logic [34:0]           diff;
   logic                  ge;

   always_comb begin
      if (op_ff) begin
         cmp_a = {rem_ff[31:0], rad_ff[63:62]};
         cmp_b = {q_ff[31:0], 2'b01};
      end else begin
         cmp_a = {8'b0, rem_ff[24:0], rad_ff[63]};
         cmp_b = {9'b0, den_ff};
      end
      diff = {1'b0, cmp_a} - {1'b0, cmp_b};
      ge   = !diff[34];

      run_in  = run_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      if (ds_req.start) begin
         run_in = 1'b1;
         op_in  = ds_req.op_sqrt;
         cnt_in = ds_req.op_sqrt ? 6'd31 : 6'd55;
         rad_in = ds_req.op_sqrt ? ds_num : {ds_num[55:0], 8'b0};
         rem_in = '0;
         q_in   = '0;
         den_in = ds_den;
      end else if (run_ff) begin
         rem_in = ge ? diff[33:0] : cmp_a;
         q_in   = {q_ff[DS_Q_W-2:0], ge};
         rad_in = op_ff ? {rad_ff[61:0], 2'b00} : {rad_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign ds_done = done_ff;
   assign ds_q    = q_ff;

endmodule

/* rtl/core/force_to_wheel_speeds.sv */
// Add and clear items keep the block ready. A compute item holds the sequencer
// through five divisions, two square roots and the multiplies and sequencing,
// and its result becomes valid as the sequencer returns to idle; zero heading
// or zero speed ends early, a stalled result waits.
// Synchronous active-high reset clears the force sums, the sticky saturation
// flag, the registers to their defaults and the sequencer; no result is valid.
module force_to_wheel_speeds (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // force_x, force_y, heading_x, heading_y, velocity_x, velocity_y
   input  logic [fws_pkg::REQ_DATA_W-1:0]       req_tdata,
   // mode
   input  logic [fws_pkg::MODE_W-1:0]           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // right_speed, left_speed
   output logic [fws_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // clamped, degenerate
   output logic [fws_pkg::RSP_USER_W-1:0]       rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fws_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fws_pkg::CSR_DATA_W-1:0]       csr_data
);
   import fws_pkg::*;

   state_type state_ff, state_in;

   logic signed [31:0] sum_x_ff, sum_y_ff;
   logic               sumsat_ff;
   logic [23:0]        im_ff;
   logic [22:0]        gain_ff, maxs_ff;
   logic signed [23:0] hx_ff, hy_ff, vx_ff, vy_ff;
   logic signed [31:0] ax_ff, ay_ff, ats_ff, vtx_ff, vty_ff;
   logic signed [PROD_W-1:0] acc_ff;
   logic signed [56:0] dot_ff, cross_ff;
   logic [24:0]        hmag_ff;
   logic [22:0]        spd_ff;
   logic [30:0]        an_ff;
   logic [40:0]        term_ff;
   logic               sgn_ff, clamp_ff, degen_ff;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   ds_req_type               ds_req;
   logic [DS_NUM_W-1:0]      ds_num;
   logic [DS_DEN_W-1:0]      ds_den;
   logic                     ds_done;
   logic [DS_Q_W-1:0]        ds_q;

   logic req_xfer, out_free;
   logic [MODE_W-1:0] mode;
   logic signed [23:0] fx, fy;
   logic [32:0] add_x, add_y, sat_sc, sat_ats, sat_vt;
   logic signed [PROD_W-1:0] sum_sq, q66, ats_cand, vt_cand, prod_mag;
   logic signed [56:0] dot_mag, cross_mag;
   logic root_over;
   logic [22:0] spd_new;
   logic signed [42:0] spd43, term43, lim43, r_full, l_full;
   logic r_hi, l_hi, l_lo;
   logic [23:0] r_val, l_val;

   fws_mul u_mul (
      .clock  (clock),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod_ff(prod_ff)
   );

   fws_divsqrt u_ds (
      .clock  (clock),
      .reset  (reset),
      .ds_req (ds_req),
      .ds_num (ds_num),
      .ds_den (ds_den),
      .ds_done(ds_done),
      .ds_q   (ds_q)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign mode       = req_tuser;
   assign fx         = req_tdata[23:0];
   assign fy         = req_tdata[47:24];
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Shared arithmetic feeding the sequencer.
   always_comb begin
      add_x     = sat32(PROD_W'(sum_x_ff) + PROD_W'(fx));
      add_y     = sat32(PROD_W'(sum_y_ff) + PROD_W'(fy));
      sat_sc    = sat32(scale_im(prod_ff));
      sum_sq    = acc_ff + prod_ff;
      q66       = PROD_W'(ds_q);
      ats_cand  = dot_ff[56] ? -q66 : q66;
      sat_ats   = sat32(ats_cand);
      vt_cand   = ((state_ff == ST_DVX) ? PROD_W'(vx_ff) : PROD_W'(vy_ff))
                  + (sgn_ff ? -q66 : q66);
      sat_vt    = sat32(vt_cand);
      prod_mag  = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
      dot_mag   = dot_ff[56] ? -dot_ff : dot_ff;
      cross_mag = cross_ff[56] ? -cross_ff : cross_ff;
      root_over = ds_q[31:0] > {9'b0, maxs_ff};
      spd_new   = root_over ? maxs_ff : ds_q[22:0];
      spd43     = 43'(spd_ff);
      term43    = 43'(term_ff);
      lim43     = 43'(maxs_ff);
      r_full    = spd43 + term43;
      l_full    = spd43 - term43;
      r_hi      = r_full > lim43;
      l_hi      = l_full > lim43;
      l_lo      = l_full < -lim43;
      r_val     = r_hi ? 24'(maxs_ff) : r_full[23:0];
      l_val     = l_hi ? 24'(maxs_ff) : (l_lo ? -24'(maxs_ff) : l_full[23:0]);
   end

   // Sequencer: next state, multiplier operands and divide/sqrt requests.
   always_comb begin
      state_in       = state_ff;
      mul_a          = '0;
      mul_b          = '0;
      ds_req.start   = 1'b0;
      ds_req.op_sqrt = 1'b0;
      ds_num         = '0;
      ds_den         = hmag_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && mode == MODE_COMPUTE) state_in = ST_AX;
         end
         ST_AX: begin
            mul_a = MUL_W'(sum_x_ff); mul_b = MUL_W'(im_ff); state_in = ST_AY;
         end
         ST_AY: begin
            mul_a = MUL_W'(sum_y_ff); mul_b = MUL_W'(im_ff); state_in = ST_HX2;
         end
         ST_HX2: begin
            mul_a = MUL_W'(hx_ff); mul_b = MUL_W'(hx_ff); state_in = ST_HY2;
         end
         ST_HY2: begin
            mul_a = MUL_W'(hy_ff); mul_b = MUL_W'(hy_ff); state_in = ST_H2;
         end
         ST_H2: begin
            if (sum_sq == '0) begin
               state_in = ST_FIN;
            end else begin
               ds_req.start = 1'b1; ds_req.op_sqrt = 1'b1;
               ds_num = sum_sq[DS_NUM_W-1:0];
               state_in = ST_SQH;
            end
         end
         ST_SQH: if (ds_done) state_in = ST_D1;
         ST_D1: begin
            mul_a = MUL_W'(ax_ff); mul_b = MUL_W'(hx_ff); state_in = ST_D2;
         end
         ST_D2: begin
            mul_a = MUL_W'(ay_ff); mul_b = MUL_W'(hy_ff); state_in = ST_D3;
         end
         ST_D3: begin
            mul_a = MUL_W'(ay_ff); mul_b = MUL_W'(hx_ff); state_in = ST_D4;
         end
         ST_D4: begin
            mul_a = MUL_W'(ax_ff); mul_b = MUL_W'(hy_ff); state_in = ST_D5;
         end
         ST_D5: begin
            ds_req.start = 1'b1;
            ds_num = DS_NUM_W'(dot_mag[55:0]);
            state_in = ST_DVA;
         end
         ST_DVA: if (ds_done) state_in = ST_PX;
         ST_PX: begin
            mul_a = MUL_W'(ats_ff); mul_b = MUL_W'(hx_ff); state_in = ST_PXD;
         end
         ST_PXD: begin
            ds_req.start = 1'b1;
            ds_num = DS_NUM_W'(prod_mag[55:0]);
            state_in = ST_DVX;
         end
         ST_DVX: if (ds_done) state_in = ST_PY;
         ST_PY: begin
            mul_a = MUL_W'(ats_ff); mul_b = MUL_W'(hy_ff); state_in = ST_PYD;
         end
         ST_PYD: begin
            ds_req.start = 1'b1;
            ds_num = DS_NUM_W'(prod_mag[55:0]);
            state_in = ST_DVY;
         end
         ST_DVY: if (ds_done) state_in = ST_V2X;
         ST_V2X: begin
            mul_a = MUL_W'(vtx_ff); mul_b = MUL_W'(vtx_ff); state_in = ST_V2Y;
         end
         ST_V2Y: begin
            mul_a = MUL_W'(vty_ff); mul_b = MUL_W'(vty_ff); state_in = ST_V2S;
         end
         ST_V2S: begin
            ds_req.start = 1'b1; ds_req.op_sqrt = 1'b1;
            ds_num = sum_sq[DS_NUM_W-1:0];
            state_in = ST_SQS;
         end
         ST_SQS: begin
            if (ds_done) state_in = (spd_new == '0) ? ST_FIN : ST_AN;
         end
         ST_AN: begin
            ds_req.start = 1'b1;
            ds_num = DS_NUM_W'(cross_mag[55:0]);
            state_in = ST_DVN;
         end
         ST_DVN: if (ds_done) state_in = ST_PT;
         ST_PT: begin
            mul_a = MUL_W'(gain_ff); mul_b = MUL_W'(an_ff); state_in = ST_PTD;
         end
         ST_PTD: begin
            ds_req.start = 1'b1;
            ds_num = DS_NUM_W'(prod_ff[55:0]);
            ds_den = DS_DEN_W'(spd_ff);
            state_in = ST_DVT;
         end
         ST_DVT: if (ds_done) state_in = ST_FIN;
         ST_FIN: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control state: accumulators, registers and the output stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sumsat_ff    <= 1'b0;
         im_ff        <= 24'h01_0000;
         gain_ff      <= 23'd4096;
         maxs_ff      <= 23'h7F_FFFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            priority case (csr_index)
               CSR_INVERSE_MASS: im_ff   <= csr_data;
               CSR_TURN_GAIN:    gain_ff <= csr_data[22:0];
               CSR_MAX_SPEED:    maxs_ff <= csr_data[22:0];
               default: ;
            endcase
         end
         if (req_xfer && mode == MODE_ADD) begin
            sum_x_ff <= add_x[31:0];
            sum_y_ff <= add_y[31:0];
            if (add_x[32] || add_y[32]) sumsat_ff <= 1'b1;
         end else if (req_xfer && mode == MODE_CLEAR) begin
            sum_x_ff  <= '0;
            sum_y_ff  <= '0;
            sumsat_ff <= 1'b0;
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_FIN && out_free) rsp_valid_ff <= 1'b1;
      end
   end

   // Working registers of the compute sequence.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && mode == MODE_COMPUTE) begin
               hx_ff    <= req_tdata[71:48];
               hy_ff    <= req_tdata[95:72];
               vx_ff    <= req_tdata[119:96];
               vy_ff    <= req_tdata[143:120];
               clamp_ff <= sumsat_ff;
               degen_ff <= 1'b0;
            end
         end
         ST_AY: begin
            ax_ff <= sat_sc[31:0];
            if (sat_sc[32]) clamp_ff <= 1'b1;
         end
         ST_HX2: begin
            ay_ff <= sat_sc[31:0];
            if (sat_sc[32]) clamp_ff <= 1'b1;
         end
         ST_HY2, ST_V2Y: acc_ff <= prod_ff;
         ST_H2: if (sum_sq == '0) degen_ff <= 1'b1;
         ST_SQH: if (ds_done) hmag_ff <= ds_q[24:0];
         ST_D2: dot_ff <= prod_ff[56:0];
         ST_D3: dot_ff <= dot_ff + prod_ff[56:0];
         ST_D4: cross_ff <= prod_ff[56:0];
         ST_D5: cross_ff <= cross_ff - prod_ff[56:0];
         ST_DVA: begin
            if (ds_done) begin
               ats_ff <= sat_ats[31:0];
               if (sat_ats[32]) clamp_ff <= 1'b1;
            end
         end
         ST_PXD, ST_PYD: sgn_ff <= prod_ff[PROD_W-1];
         ST_DVX: begin
            if (ds_done) begin
               vtx_ff <= sat_vt[31:0];
               if (sat_vt[32]) clamp_ff <= 1'b1;
            end
         end
         ST_DVY: begin
            if (ds_done) begin
               vty_ff <= sat_vt[31:0];
               if (sat_vt[32]) clamp_ff <= 1'b1;
            end
         end
         ST_SQS: begin
            if (ds_done) begin
               spd_ff <= spd_new;
               if (root_over) clamp_ff <= 1'b1;
               if (spd_new == '0) degen_ff <= 1'b1;
            end
         end
         ST_DVN: begin
            if (ds_done) begin
               if (ds_q > DS_Q_W'(SAT_POS[31:0])) begin
                  an_ff    <= 31'h7FFF_FFFF;
                  clamp_ff <= 1'b1;
               end else begin
                  an_ff <= ds_q[30:0];
               end
            end
         end
         ST_DVT: begin
            if (ds_done) begin
               if (ds_q > TERM_LIMIT) begin
                  term_ff  <= TERM_LIMIT[40:0];
                  clamp_ff <= 1'b1;
               end else begin
                  term_ff <= ds_q[40:0];
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               if (degen_ff) begin
                  rsp_data_ff <= '0;
                  rsp_user_ff <= {1'b1, clamp_ff};
               end else begin
                  rsp_data_ff <= {l_val, r_val};
                  rsp_user_ff <= {1'b0, clamp_ff | r_hi | l_hi | l_lo};
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* rtl/core/fws_checker.sv */
// Port-level checks for force_to_wheel_speeds, attached with a bind.
// Depends on fws_pkg.
module fws_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [fws_pkg::REQ_DATA_W-1:0]       req_tdata,
   input logic [fws_pkg::MODE_W-1:0]           req_tuser,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [fws_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input logic [fws_pkg::RSP_USER_W-1:0]       rsp_tuser,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [fws_pkg::CSR_IDX_W-1:0]        csr_index,
   input logic [fws_pkg::CSR_DATA_W-1:0]       csr_data
);
   import fws_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset left the block busy");

   a_busy_after_compute: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == MODE_COMPUTE |=> !req_tready)
      else $error("compute transfer did not occupy the sequencer");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0)
      else $error("degenerate result with nonzero speeds");

   a_right_ge_left: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[23:0]) >= $signed(rsp_tdata[47:24]))
      else $error("left wheel faster than right wheel");

endmodule

bind force_to_wheel_speeds fws_checker u_fws_checker (.*);
